// ----- sv/prq_pkg.sv -----
// Package for the priority run queue: types, constants and codes.
`default_nettype none
package prq_pkg;
  localparam int unsigned IdW = 6;
  localparam int unsigned Slots = 64;
  localparam int unsigned Levels = 11;
  localparam int unsigned LvlW = 4;
  localparam int unsigned SpecialLevel = 5;
  localparam int unsigned MaxEntries = 64;
  localparam int unsigned CntW = 7;

  typedef enum logic [1:0] {
    REQ_ADD = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SELECT = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_EMPTY = 3'd1,
    ST_BAD_PRIO = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL = 3'd4
  } status_e;

  // link: bit IdW is the null flag
  typedef struct packed {
    logic nul;
    logic [IdW-1:0] id;
  } link_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [IdW-1:0] task_id;
    logic [3:0] task_priority;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic picked_valid;
    logic [IdW-1:0] picked_id;
  } rsp_t;
endpackage
`default_nettype wire

// ----- sv/priority_run_queue.sv -----
// Top level of the priority run queue: sequencer over head/tail registers and link memory.
//
// Usage: raise start_i with a request on req_i while busy_o is low; the beat
// is taken at that edge. Requests: add (append id to the tail of a priority
// list), remove (unlink id from the named list), select (pop the head of
// priority five first, then the lowest non-empty priority). Every request
// yields one result on rsp_o, marked by done_o for a single cycle; the
// receiver cannot stall it.
// An add or select that changes the lists passes through decode, a link
// memory step (S_RD for add, S_POP for select), then the result cycle.
// A rejected request, an empty select or an unused code goes from decode
// straight to the result cycle. Remove walks the list one node per cycle
// through the single link memory read port and unlinks the id where it is
// found; the walk ends at the list's tail when the id is missing from a
// list (up to 64 nodes). busy_o stays high through the result cycle, so
// the next request is taken at the end of the cycle after done_o.
// Reset clears every list, the queued marks and the count at once; the link
// memory needs no clearing since it is only read for queued ids.
`default_nettype none
module priority_run_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic busy_o,
  input  wire prq_pkg::req_t req_i,
  output logic done_o,
  output prq_pkg::rsp_t rsp_o
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_RD   = 7'b0000100,
    S_WALK = 7'b0001000,
    S_POP  = 7'b0010000,
    S_UNL  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  prq_pkg::req_t req_q;
  prq_pkg::link_t head_q [prq_pkg::Levels];
  prq_pkg::link_t tail_q [prq_pkg::Levels];
  logic [prq_pkg::Slots-1:0] mark_q;
  logic [prq_pkg::CntW-1:0] cnt_q;
  logic [prq_pkg::LvlW-1:0] lvl_q;
  prq_pkg::link_t cur_q, prev_q;
  prq_pkg::rsp_t rsp_q;
  prq_pkg::rsp_t dec_rsp;

  // link memory
  prq_pkg::link_t mem [prq_pkg::Slots];
  prq_pkg::link_t rd_q;
  logic [prq_pkg::IdW-1:0] rd_addr, wr_addr;
  prq_pkg::link_t wr_data;
  logic rd_en, wr_en;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  logic prio_ok;
  logic [prq_pkg::LvlW-1:0] pick_lvl;
  logic pick_any;
  assign prio_ok = req_q.task_priority < prq_pkg::LvlW'(prq_pkg::Levels);

  // select priority: special level first, then lowest non-empty
  always_comb begin
    pick_any = 1'b0;
    pick_lvl = '0;
    for (int i = prq_pkg::Levels - 1; i >= 0; i--) begin
      if (!head_q[i].nul) begin
        pick_any = 1'b1;
        pick_lvl = prq_pkg::LvlW'(i);
      end
    end
    if (!head_q[prq_pkg::SpecialLevel].nul) pick_lvl = prq_pkg::LvlW'(prq_pkg::SpecialLevel);
  end

  // result as known at decode; a remove miss is found later on the walk
  always_comb begin
    dec_rsp = '0;
    unique case (req_q.req_type)
      prq_pkg::REQ_ADD: begin
        if (cnt_q >= prq_pkg::CntW'(prq_pkg::MaxEntries)) dec_rsp.status = prq_pkg::ST_FULL;
        else if (!prio_ok) dec_rsp.status = prq_pkg::ST_BAD_PRIO;
        else if (mark_q[req_q.task_id]) dec_rsp.status = prq_pkg::ST_FULL;
      end
      prq_pkg::REQ_REMOVE: begin
        if (!prio_ok) dec_rsp.status = prq_pkg::ST_BAD_PRIO;
        else if (head_q[lvl_q].nul) dec_rsp.status = prq_pkg::ST_NOT_FOUND;
      end
      prq_pkg::REQ_SELECT: begin
        if (cnt_q == '0 || !pick_any) dec_rsp.status = prq_pkg::ST_EMPTY;
        else begin
          dec_rsp.picked_valid = 1'b1;
          dec_rsp.picked_id = head_q[pick_lvl].id;
        end
      end
      default: ;
    endcase
  end

  prq_pkg::link_t nul_link;
  assign nul_link = '{nul: 1'b1, id: '0};

  always_comb begin
    state_d = state_q;
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = nul_link;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_DEC;
      S_DEC: begin
        unique case (req_q.req_type)
          prq_pkg::REQ_ADD: begin
            if (cnt_q >= prq_pkg::CntW'(prq_pkg::MaxEntries) || !prio_ok ||
                mark_q[req_q.task_id]) begin
              state_d = S_DONE;
            end else begin
              wr_en = 1'b1;
              wr_addr = req_q.task_id;
              state_d = S_RD;
            end
          end
          prq_pkg::REQ_REMOVE: begin
            if (!prio_ok || head_q[lvl_q].nul) state_d = S_DONE;
            else begin
              rd_en = 1'b1;
              rd_addr = head_q[lvl_q].id;
              state_d = S_WALK;
            end
          end
          prq_pkg::REQ_SELECT: begin
            if (cnt_q == '0 || !pick_any) state_d = S_DONE;
            else begin
              rd_en = 1'b1;
              rd_addr = head_q[pick_lvl].id;
              state_d = S_POP;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RD: begin
        // add: link old tail to new id
        if (!head_q[lvl_q].nul) begin
          wr_en = 1'b1;
          wr_addr = tail_q[lvl_q].id;
          wr_data = '{nul: 1'b0, id: req_q.task_id};
        end
        state_d = S_DONE;
      end
      S_WALK: begin
        // rd_q = next of cur_q
        if (cur_q.id == req_q.task_id) state_d = S_UNL;
        else if (rd_q.nul) state_d = S_DONE;
        else state_d = S_RD;
        if (cur_q.id != req_q.task_id && !rd_q.nul) begin
          rd_en = 1'b1;
          rd_addr = rd_q.id;
          state_d = S_WALK;
        end
      end
      S_UNL: begin
        if (!prev_q.nul) begin
          wr_en = 1'b1;
          wr_addr = prev_q.id;
          wr_data = rd_q;
        end
        state_d = S_DONE;
      end
      S_POP: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mark_q <= '0;
      cnt_q <= '0;
      for (int i = 0; i < prq_pkg::Levels; i++) begin
        head_q[i] <= '{nul: 1'b1, id: '0};
        tail_q[i] <= '{nul: 1'b1, id: '0};
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_RD: begin
          if (head_q[lvl_q].nul) head_q[lvl_q] <= '{nul: 1'b0, id: req_q.task_id};
          tail_q[lvl_q] <= '{nul: 1'b0, id: req_q.task_id};
          mark_q[req_q.task_id] <= 1'b1;
          cnt_q <= cnt_q + 1'b1;
        end
        S_POP: begin
          head_q[lvl_q] <= rd_q;
          if (rd_q.nul) tail_q[lvl_q] <= nul_link;
          mark_q[cur_q.id] <= 1'b0;
          cnt_q <= cnt_q - 1'b1;
        end
        S_UNL: begin
          if (prev_q.nul) head_q[lvl_q] <= rd_q;
          if (rd_q.nul) tail_q[lvl_q] <= prev_q;
          mark_q[cur_q.id] <= 1'b0;
          cnt_q <= cnt_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        req_q <= req_i;
        lvl_q <= req_i.task_priority;
        rsp_q <= '0;
      end
      S_DEC: begin
        prev_q <= nul_link;
        rsp_q <= dec_rsp;
        unique case (req_q.req_type)
          prq_pkg::REQ_REMOVE: cur_q <= head_q[lvl_q];
          prq_pkg::REQ_SELECT: begin
            lvl_q <= pick_lvl;
            cur_q <= head_q[pick_lvl];
          end
          default: ;
        endcase
      end
      S_WALK: begin
        if (cur_q.id != req_q.task_id) begin
          if (rd_q.nul) rsp_q.status <= prq_pkg::ST_NOT_FOUND;
          prev_q <= cur_q;
          cur_q <= rd_q;
        end
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign rsp_o = rsp_q;

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= prq_pkg::CntW'(prq_pkg::MaxEntries)) else $error("count overflow");
  a_cnt_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> $countones(mark_q) == int'(cnt_q)) else $error("count mismatch");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held twice");
  a_pick_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.picked_valid |-> rsp_o.status == prq_pkg::ST_OK) else $error("bad pick");
endmodule
`default_nettype wire

// ----- tb/sv/prq_checker.sv -----
// Checker for the priority run queue: shadow lists, expected-result queue and comparison.
`default_nettype none
module prq_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic busy_i,
  input  wire prq_pkg::req_t req_i,
  input  wire logic done_i,
  input  wire prq_pkg::rsp_t rsp_i,
  output int errors_o,
  output int pending_o,
  output int results_o,
  output int picks_o
);
  prq_pkg::link_t lvl_head [prq_pkg::Levels];
  prq_pkg::link_t lvl_tail [prq_pkg::Levels];
  prq_pkg::link_t next_of [prq_pkg::Slots];
  logic           is_queued [prq_pkg::Slots];
  int             n_queued;
  prq_pkg::rsp_t  expected_rsp [$];

  localparam prq_pkg::link_t NullLink = '{nul: 1'b1, id: '0};

  function automatic prq_pkg::rsp_t pop_level(int lvl);
    prq_pkg::rsp_t o;
    logic [prq_pkg::IdW-1:0] id;
    prq_pkg::link_t nx;
    id = lvl_head[lvl].id;
    nx = next_of[id];
    lvl_head[lvl] = nx;
    if (nx.nul) lvl_tail[lvl] = NullLink;
    next_of[id] = NullLink;
    is_queued[id] = 1'b0;
    if (n_queued > 0) n_queued--;
    o.status = prq_pkg::ST_OK;
    o.picked_valid = 1'b1;
    o.picked_id = id;
    return o;
  endfunction

  function automatic prq_pkg::rsp_t apply_queue_op(prq_pkg::req_t r);
    prq_pkg::rsp_t o;
    prq_pkg::link_t cur;
    prq_pkg::link_t prev;
    prq_pkg::link_t nx;
    int p;
    bit found;
    o = '0;
    o.status = prq_pkg::ST_OK;
    p = r.task_priority;
    case (prq_pkg::req_e'(r.req_type))
      prq_pkg::REQ_ADD: begin
        if (n_queued >= prq_pkg::MaxEntries) o.status = prq_pkg::ST_FULL;
        else if (p >= prq_pkg::Levels) o.status = prq_pkg::ST_BAD_PRIO;
        else if (is_queued[r.task_id]) o.status = prq_pkg::ST_FULL;
        else begin
          next_of[r.task_id] = NullLink;
          if (lvl_head[p].nul) lvl_head[p] = '{nul: 1'b0, id: r.task_id};
          else next_of[lvl_tail[p].id] = '{nul: 1'b0, id: r.task_id};
          lvl_tail[p] = '{nul: 1'b0, id: r.task_id};
          is_queued[r.task_id] = 1'b1;
          n_queued++;
        end
      end
      prq_pkg::REQ_REMOVE: begin
        if (p >= prq_pkg::Levels) o.status = prq_pkg::ST_BAD_PRIO;
        else begin
          cur = lvl_head[p];
          prev = NullLink;
          found = 0;
          for (int i = 0; i < prq_pkg::Slots && !cur.nul && !found; i++) begin
            if (cur.id == r.task_id) begin
              nx = next_of[r.task_id];
              if (prev.nul) lvl_head[p] = nx;
              else next_of[prev.id] = nx;
              if (nx.nul) lvl_tail[p] = prev;
              next_of[r.task_id] = NullLink;
              is_queued[r.task_id] = 1'b0;
              if (n_queued > 0) n_queued--;
              found = 1;
            end else begin
              prev = cur;
              cur = next_of[cur.id];
            end
          end
          if (!found) o.status = prq_pkg::ST_NOT_FOUND;
        end
      end
      prq_pkg::REQ_SELECT: begin
        if (n_queued == 0) o.status = prq_pkg::ST_EMPTY;
        else if (!lvl_head[prq_pkg::SpecialLevel].nul) o = pop_level(prq_pkg::SpecialLevel);
        else begin
          o.status = prq_pkg::ST_EMPTY;
          for (int i = 0; i < prq_pkg::Levels; i++) begin
            if (!lvl_head[i].nul) begin
              o = pop_level(i);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // shadow state is updated in place by the functions, so its assignments are blocking
  always @(posedge clk_i or negedge rst_ni) begin
    prq_pkg::rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < prq_pkg::Levels; i++) begin
        lvl_head[i] = NullLink;
        lvl_tail[i] = NullLink;
      end
      for (int i = 0; i < prq_pkg::Slots; i++) begin
        next_of[i] = NullLink;
        is_queued[i] = 1'b0;
      end
      n_queued = 0;
      errors_o <= 0;
      results_o <= 0;
      picks_o <= 0;
      expected_rsp.delete();
    end else begin
      // result beat first: the request taken at this edge cannot answer at it
      if (done_i) begin
        results_o <= results_o + 1;
        if (expected_rsp.size() == 0) begin
          if (errors_o < 10) $display("ERROR: result %p with none expected", rsp_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_rsp.pop_front();
          if (want.picked_valid) picks_o <= picks_o + 1;
          if (rsp_i.status !== want.status || rsp_i.picked_valid !== want.picked_valid ||
              rsp_i.picked_id !== want.picked_id) begin
            if (errors_o < 10)
              $display("ERROR: status %0d/%0d valid %0d/%0d id %0d/%0d (exp/got)",
                       want.status, rsp_i.status, want.picked_valid, rsp_i.picked_valid,
                       want.picked_id, rsp_i.picked_id);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (start_i && !busy_i) expected_rsp.push_back(apply_queue_op(req_i));
    end
  end

  assign pending_o = expected_rsp.size();
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench top for the priority run queue: clock, reset, request stimulus and verdict.
`default_nettype none
module tb;
  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  prq_pkg::req_t  req_i = '0;
  logic           busy_o;
  logic           done_o;
  prq_pkg::rsp_t  rsp_o;
  int    errors, pending, results, picks;
  int    idle_cycles = 0;
  int    burst_left = 0;
  int    sent = 0;
  int    prio_of [prq_pkg::Slots];

  localparam int WatchdogLimit = 5000;
  localparam int ReqW = $bits(prq_pkg::req_t);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  priority_run_queue u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .done_o, .rsp_o
  );

  prq_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_i, .done_i(done_o), .rsp_i(rsp_o),
    .errors_o(errors), .pending_o(pending), .results_o(results), .picks_o(picks)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one request beat; holds start until the block takes it
  task automatic issue_request(prq_pkg::req_e kind, int id, int prio);
    start_i <= 1'b1;
    req_i <= '{req_type: kind, task_id: id[prq_pkg::IdW-1:0], task_priority: prio[3:0]};
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    sent++;
    if (kind == prq_pkg::REQ_ADD && prio < prq_pkg::Levels) prio_of[id] = prio;
    if (kind == prq_pkg::REQ_REMOVE) prio_of[id] = -1;
  endtask

  task automatic random_gap();
    int n;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    case ($urandom_range(0, 19))
      0: burst_left = $urandom_range(10, 40);
      1, 2: n = $urandom_range(15, 60);
      default: n = $urandom_range(0, 3);
    endcase
    if (burst_left > 0 || n == 0) return;
    start_i <= 1'b0;
    req_i <= prq_pkg::req_t'(ReqW'($urandom));
    repeat (n) @(posedge clk_i);
  endtask

  task automatic fill_all();
    for (int i = 0; i < prq_pkg::Slots; i++) begin
      issue_request(prq_pkg::REQ_ADD, i, $urandom_range(0, prq_pkg::Levels - 1));
      random_gap();
    end
    issue_request(prq_pkg::REQ_ADD, $urandom_range(0, 63), $urandom_range(0, 15));
  endtask

  initial begin
    int id, p, r;
    for (int i = 0; i < prq_pkg::Slots; i++) prio_of[i] = -1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty select, bad priorities, misses, duplicates, special level, unused codes
    issue_request(prq_pkg::REQ_SELECT, 0, 0);
    issue_request(prq_pkg::REQ_ADD, 7, 15);
    issue_request(prq_pkg::REQ_REMOVE, 7, 11);
    issue_request(prq_pkg::REQ_REMOVE, 7, 3);
    issue_request(prq_pkg::REQ_NONE, 63, 15);
    issue_request(prq_pkg::REQ_ADD, 0, 0);
    issue_request(prq_pkg::REQ_ADD, 63, 10);
    issue_request(prq_pkg::REQ_ADD, 21, 5);
    issue_request(prq_pkg::REQ_ADD, 42, 5);
    issue_request(prq_pkg::REQ_ADD, 0, 3);
    issue_request(prq_pkg::REQ_ADD, 9, 0);
    issue_request(prq_pkg::REQ_ADD, 12, 0);
    issue_request(prq_pkg::REQ_REMOVE, 9, 0);
    issue_request(prq_pkg::REQ_REMOVE, 63, 9);
    issue_request(prq_pkg::REQ_SELECT, 0, 0);
    issue_request(prq_pkg::REQ_SELECT, 0, 0);
    issue_request(prq_pkg::REQ_SELECT, 0, 0);
    issue_request(prq_pkg::REQ_REMOVE, 12, 0);
    issue_request(prq_pkg::REQ_SELECT, 0, 0);
    issue_request(prq_pkg::REQ_SELECT, 0, 0);
    issue_request(prq_pkg::REQ_NONE, 0, 0);

    while (sent < 920) begin
      if (sent % 300 == 150) fill_all();
      r = $urandom_range(0, 99);
      id = $urandom_range(0, 63);
      if (r < 40) begin
        p = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 15) : $urandom_range(0, 10);
        issue_request(prq_pkg::REQ_ADD, id, p);
      end else if (r < 65) begin
        // when the id is believed queued, mostly aim at its own level
        p = prio_of[id];
        if (p < 0 || $urandom_range(0, 4) == 0) p = $urandom_range(0, 15);
        issue_request(prq_pkg::REQ_REMOVE, id, p);
      end else if (r < 96) issue_request(prq_pkg::REQ_SELECT, id, $urandom_range(0, 15));
      else issue_request(prq_pkg::REQ_NONE, id, $urandom_range(0, 15));
      random_gap();
    end
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Run covered %0d requests and %0d results, %0d of them picked tasks,",
             sent, results, picks);
    $display("including full-queue fills, bad priorities, misses and unused codes.");
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
sv/prq_pkg.sv
sv/priority_run_queue.sv
tb/sv/prq_checker.sv
tb/sv/tb.sv
